[sv/dpa_pkg.sv]
`timescale 1ns / 1ps
package dpa_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int SIZE_W    = 33;
   localparam int REQ_W     = 32;
   localparam int UNIT_W    = 21;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [UNIT_W-1:0] UNIT_RST = 21'd1024;
   localparam logic [REQ_W-1:0]  SYS_RST  = 32'd1048576;
   localparam logic [REQ_W-1:0]  USER_RST = 32'd67108864;

   typedef enum logic [1:0] {
      ACT_INIT  = 2'd0,
      ACT_ALLOC = 2'd1,
      ACT_FREE  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOSPC  = 2'd1,
      ST_BADSLT = 2'd2,
      ST_BADCFG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_UNIT   = 2'd0,
      REG_SYS    = 2'd1,
      REG_USER   = 2'd2,
      REG_POLICY = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_WRITE  = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic              used;
      logic [SIZE_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      logic        wr_size;
      logic        wr_addr;
      logic        wr_used;
      entry_type   data;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT_DIV1,
      S_INIT_DIV2,
      S_INIT_W0,
      S_INIT_W1,
      S_AL_DIV,
      S_AL_MOD,
      S_AL_SCAN,
      S_CMP_WALK,
      S_CMP_APPEND,
      S_PL_SPLIT,
      S_PL_WR,
      S_FR_SUM,
      S_FR_WR,
      S_FR_REM,
      S_DONE
   } state_type;

endpackage

[sv/dpa_rem.sv]
`timescale 1ns / 1ps
module dpa_rem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dpa_pkg::REQ_W-1:0]  dividend,
   input  logic [dpa_pkg::UNIT_W-1:0] divisor,
   output logic                      done,
   output logic [dpa_pkg::UNIT_W-1:0] remainder
);
   import dpa_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [REQ_W-1:0]  a_ff, a_in;
   logic [UNIT_W-1:0] b_ff, b_in;
   logic [UNIT_W-1:0] r_ff, r_in;
   logic [UNIT_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      trial   = {r_ff, a_ff[REQ_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = dividend;
         b_in    = divisor;
         r_in    = '0;
      end else if (busy_ff) begin
         a_in = {a_ff[REQ_W-2:0], 1'b0};
         if (trial >= {1'b0, b_ff}) begin
            r_in = UNIT_W'(trial - {1'b0, b_ff});
         end else begin
            r_in = UNIT_W'(trial);
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff;

endmodule

[sv/dpa_cell.sv]
`timescale 1ns / 1ps
module dpa_cell #(
   parameter int                 CELL_INDEX  = 0,
   parameter int                 IDX_W       = 4,
   parameter dpa_pkg::entry_type RESET_VALUE = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dpa_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]      pos,
   input  dpa_pkg::entry_type    left,
   input  dpa_pkg::entry_type    right,
   output dpa_pkg::entry_type    q
);
   import dpa_pkg::*;

   entry_type ent_ff, ent_in;
   int        p;

   always_comb begin
      p      = int'(pos);
      ent_in = ent_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (CELL_INDEX == p + 1) begin
               ent_in = cmd.data;
            end else if (CELL_INDEX > p + 1) begin
               ent_in = left;
            end
         end
         CELL_REMOVE: begin
            if (CELL_INDEX >= p) begin
               ent_in = right;
            end
         end
         CELL_WRITE: begin
            if (CELL_INDEX == p) begin
               if (cmd.wr_size) ent_in.size = cmd.data.size;
               if (cmd.wr_addr) ent_in.addr = cmd.data.addr;
               if (cmd.wr_used) ent_in.used = cmd.data.used;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= RESET_VALUE;
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign q = ent_ff;

endmodule

[sv/dynamic_partition_allocator_core.sv]
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser action, tdata request_bytes, partition_slot
// rsp       out  rsp_tvalid/rsp_tready  tdata status, slot, address, bytes, did_compact
// csr       in   csr_we                 csr_index, csr_wdata
// One word at a time. Init: two remainder passes (system size, then user size).
// Allocate: a remainder pass, then a scan over the table entries;
// compaction walks the entries, then rescans. Free: merges the slot with free neighbours.
// Reset loads the default table (system used, user free) at once.
// A finished word waits in the output register; the next word is taken meanwhile.
module dynamic_partition_allocator_core #(
   parameter int TABLE_DEPTH = dpa_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [31:0] request_bytes, [35:32] partition_slot
   input  logic [dpa_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [1:0] status, [5:2] granted_slot, [37:6] granted_address,
   // [69:38] granted_bytes, [70] did_compact
   output logic [dpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);
   import dpa_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   state_type         state_ff, state_in;
   logic [UNIT_W-1:0] unit_ff;
   logic [REQ_W-1:0]  sys_ff, user_ff;
   logic              policy_ff;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]  top_ff, top_in;
   logic [SIZE_W-1:0] need_ff, need_in;
   logic [SIZE_W-1:0] total_ff, total_in;
   logic              comp_ff, comp_in;
   status_type        status_ff, status_in;
   logic [3:0]        gslot_ff, gslot_in;
   logic [REQ_W-1:0]  gaddr_ff, gaddr_in;
   logic [REQ_W-1:0]  gbytes_ff, gbytes_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              div_start;
   logic [REQ_W-1:0]  div_a;
   logic [UNIT_W-1:0] div_b;
   logic              div_done;
   logic [UNIT_W-1:0] div_rem;

   cell_cmd_type      cmd;
   logic [IDX_W-1:0]  cmd_pos;
   entry_type         cell_q [TABLE_DEPTH];

   entry_type         cur_e, prev_e;
   logic [UNIT_W-1:0] unit_eff;
   logic [REQ_W-1:0]  req_bytes;
   logic [3:0]        req_slot;
   action_type        req_act;
   logic              slot_bad, pf, nf;
   logic [CNT_W-1:0]  slot_c;
   logic [CNT_W-1:0]  ptr_nx;

   assign req_bytes = req_tdata[REQ_W-1:0];
   assign req_slot  = req_tdata[REQ_W+3:REQ_W];
   assign req_act   = action_type'(req_tuser);
   assign unit_eff  = (unit_ff == '0) ? UNIT_W'(1) : unit_ff;
   assign req_tready = (state_ff == S_IDLE);

   assign cur_e  = cell_q[ptr_ff[IDX_W-1:0]];
   assign prev_e = cell_q[IDX_W'(ptr_ff - CNT_W'(1))];
   assign ptr_nx = ptr_ff + CNT_W'(1);

   always_comb begin
      slot_c   = CNT_W'(req_slot);
      slot_bad = (req_slot == 4'd0) || (32'(req_slot) >= 32'(cnt_ff));
      pf = 1'b0;
      nf = 1'b0;
      if (!slot_bad) begin
         slot_bad = !cell_q[IDX_W'(req_slot)].used;
         pf = !cell_q[IDX_W'(req_slot - 4'd1)].used;
         if (32'(req_slot) + 32'd1 < 32'(cnt_ff)) begin
            nf = !cell_q[IDX_W'(32'(req_slot) + 32'd1)].used;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff   <= UNIT_RST;
         sys_ff    <= SYS_RST;
         user_ff   <= USER_RST;
         policy_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_UNIT:   unit_ff   <= csr_wdata[UNIT_W-1:0];
            REG_SYS:    sys_ff    <= csr_wdata;
            REG_USER:   user_ff   <= csr_wdata;
            REG_POLICY: policy_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cursor_in = cursor_ff;
      ptr_in    = ptr_ff;
      k_in      = k_ff;
      base_in   = base_ff;
      top_in    = top_ff;
      need_in   = need_ff;
      total_in  = total_ff;
      comp_in   = comp_ff;
      status_in = status_ff;
      gslot_in  = gslot_ff;
      gaddr_in  = gaddr_ff;
      gbytes_in = gbytes_ff;
      div_start = 1'b0;
      div_a     = sys_ff;
      div_b     = unit_eff;
      cmd       = '0;
      cmd.op    = CELL_HOLD;
      cmd_pos   = ptr_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            status_in = ST_OK;
            gslot_in  = '0;
            gaddr_in  = '0;
            gbytes_in = '0;
            comp_in   = 1'b0;
            if (req_tvalid) begin
               unique case (req_act)
                  ACT_INIT: begin
                     if (unit_ff == '0) begin
                        status_in = ST_BADCFG;
                        state_in  = S_DONE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_INIT_DIV1;
                     end
                  end
                  ACT_ALLOC: begin
                     need_in = {1'b0, req_bytes};
                     if (req_bytes == '0) begin
                        status_in = ST_NOSPC;
                        state_in  = S_DONE;
                     end else begin
                        div_start = 1'b1;
                        div_a     = req_bytes;
                        state_in  = S_AL_DIV;
                     end
                  end
                  ACT_FREE: begin
                     if (slot_bad) begin
                        status_in = ST_BADSLT;
                        state_in  = S_DONE;
                     end else begin
                        base_in  = pf ? slot_c - CNT_W'(1) : slot_c;
                        top_in   = nf ? slot_c + CNT_W'(1) : slot_c;
                        ptr_in   = pf ? slot_c - CNT_W'(1) : slot_c;
                        total_in = '0;
                        state_in = S_FR_SUM;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_INIT_DIV1: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  status_in = ST_BADCFG;
                  state_in  = S_DONE;
               end else begin
                  div_start = 1'b1;
                  div_a     = user_ff;
                  state_in  = S_INIT_DIV2;
               end
            end
         end
         S_INIT_DIV2: begin
            if (div_done) begin
               if (div_rem != '0 ||
                   ({1'b0, sys_ff} + {1'b0, user_ff}) > {1'b1, 32'd0}) begin
                  status_in = ST_BADCFG;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_INIT_W0;
               end
            end
         end
         S_INIT_W0: begin
            cmd.op      = CELL_WRITE;
            cmd.wr_size = 1'b1;
            cmd.wr_addr = 1'b1;
            cmd.wr_used = 1'b1;
            cmd.data    = '{used: 1'b1, addr: '0, size: {1'b0, sys_ff}};
            cmd_pos     = '0;
            cnt_in      = CNT_W'(1);
            cursor_in   = '0;
            state_in    = (user_ff != '0) ? S_INIT_W1 : S_DONE;
         end
         S_INIT_W1: begin
            cmd.op      = CELL_WRITE;
            cmd.wr_size = 1'b1;
            cmd.wr_addr = 1'b1;
            cmd.wr_used = 1'b1;
            cmd.data    = '{used: 1'b0, addr: {1'b0, sys_ff}, size: {1'b0, user_ff}};
            cmd_pos     = IDX_W'(1);
            cnt_in      = CNT_W'(2);
            state_in    = S_DONE;
         end
         S_AL_DIV: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  need_in = need_ff + SIZE_W'(unit_eff - div_rem);
               end
               ptr_in   = policy_ff ? CNT_W'(cursor_ff) : '0;
               state_in = S_AL_MOD;
            end
         end
         S_AL_MOD: begin
            if (ptr_ff >= cnt_ff) begin
               ptr_in = ptr_ff - cnt_ff;
            end else begin
               k_in     = '0;
               total_in = '0;
               state_in = S_AL_SCAN;
            end
         end
         S_AL_SCAN: begin
            if (!cur_e.used) begin
               total_in = total_ff + cur_e.size;
            end
            if (!cur_e.used && cur_e.size >= need_ff) begin
               state_in = S_PL_SPLIT;
            end else if (k_ff + CNT_W'(1) == cnt_ff) begin
               if (!comp_ff && total_in >= need_ff) begin
                  ptr_in   = CNT_W'(1);
                  state_in = S_CMP_WALK;
               end else begin
                  status_in = ST_NOSPC;
                  state_in  = S_DONE;
               end
            end else begin
               k_in   = k_ff + CNT_W'(1);
               ptr_in = (ptr_nx == cnt_ff) ? '0 : ptr_nx;
            end
         end
         S_CMP_WALK: begin
            if (ptr_ff >= cnt_ff) begin
               state_in = S_CMP_APPEND;
            end else if (cur_e.used) begin
               cmd.op        = CELL_WRITE;
               cmd.wr_addr   = 1'b1;
               cmd.data.addr = prev_e.addr + prev_e.size;
               ptr_in        = ptr_nx;
            end else begin
               cmd.op = CELL_REMOVE;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_CMP_APPEND: begin
            cmd.op      = CELL_WRITE;
            cmd.wr_size = 1'b1;
            cmd.wr_addr = 1'b1;
            cmd.wr_used = 1'b1;
            cmd.data    = '{used: 1'b0, addr: prev_e.addr + prev_e.size, size: total_ff};
            cnt_in      = cnt_ff + CNT_W'(1);
            comp_in     = 1'b1;
            ptr_in      = policy_ff ? CNT_W'(cursor_ff) : '0;
            state_in    = S_AL_MOD;
         end
         S_PL_SPLIT: begin
            if (cur_e.size > need_ff) begin
               if (cnt_ff == DEPTH_C) begin
                  status_in = ST_NOSPC;
                  state_in  = S_DONE;
               end else begin
                  cmd.op   = CELL_INSERT;
                  cmd.data = '{used: 1'b0, addr: cur_e.addr + need_ff,
                               size: cur_e.size - need_ff};
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = S_PL_WR;
               end
            end else begin
               state_in = S_PL_WR;
            end
         end
         S_PL_WR: begin
            cmd.op        = CELL_WRITE;
            cmd.wr_size   = 1'b1;
            cmd.wr_used   = 1'b1;
            cmd.data.size = need_ff;
            cmd.data.used = 1'b1;
            if (policy_ff) begin
               cursor_in = (ptr_nx == cnt_ff) ? '0 : ptr_nx[IDX_W-1:0];
            end
            gslot_in  = 4'(ptr_ff);
            gaddr_in  = cur_e.addr[REQ_W-1:0];
            gbytes_in = need_ff[REQ_W-1:0];
            state_in  = S_DONE;
         end
         S_FR_SUM: begin
            total_in = total_ff + cur_e.size;
            if (ptr_ff == top_ff) begin
               state_in = S_FR_WR;
            end else begin
               ptr_in = ptr_nx;
            end
         end
         S_FR_WR: begin
            cmd.op        = CELL_WRITE;
            cmd.wr_size   = 1'b1;
            cmd.wr_used   = 1'b1;
            cmd.data.size = total_ff;
            cmd.data.used = 1'b0;
            cmd_pos       = base_ff[IDX_W-1:0];
            k_in          = top_ff - base_ff;
            state_in      = S_FR_REM;
         end
         S_FR_REM: begin
            if (k_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cmd.op  = CELL_REMOVE;
               cmd_pos = IDX_W'(base_ff + CNT_W'(1));
               cnt_in  = cnt_ff - CNT_W'(1);
               k_in    = k_ff - CNT_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({comp_ff, gbytes_ff, gaddr_ff, gslot_ff,
                                           status_ff});
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= CNT_W'(2);
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      k_ff        <= k_in;
      base_ff     <= base_in;
      top_ff      <= top_in;
      need_ff     <= need_in;
      total_ff    <= total_in;
      comp_ff     <= comp_in;
      status_ff   <= status_in;
      gslot_ff    <= gslot_in;
      gaddr_ff    <= gaddr_in;
      gbytes_ff   <= gbytes_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   dpa_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .remainder (div_rem)
   );

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      localparam entry_type RV = (g == 0) ?
         '{used: 1'b1, addr: '0, size: {1'b0, SYS_RST}} :
         (g == 1) ? '{used: 1'b0, addr: {1'b0, SYS_RST}, size: {1'b0, USER_RST}} :
         '0;
      entry_type lft, rgt;
      if (g == 0) begin : g_l0
         assign lft = '0;
      end else begin : g_ln
         assign lft = cell_q[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_rl
         assign rgt = '0;
      end else begin : g_rn
         assign rgt = cell_q[g+1];
      end
      dpa_cell #(
         .CELL_INDEX  (g),
         .IDX_W       (IDX_W),
         .RESET_VALUE (RV)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .pos   (cmd_pos),
         .left  (lft),
         .right (rgt),
         .q     (cell_q[g])
      );
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= DEPTH_C)
      else $error("partition count out of range");
   a_sys_used: assert property (@(posedge clock) disable iff (reset)
      cell_q[0].used)
      else $error("system entry lost its used mark");
   a_scan_ptr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_AL_SCAN |-> ptr_ff < cnt_ff)
      else $error("scan pointer beyond table");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");
`endif

endmodule
